// ----- rtl/encoded_tile_validator_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ENCODED_TILE_VALIDATOR_MACROS_SVH
`define ENCODED_TILE_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETV_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETV_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/etv_pkg.sv -----
package etv_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 7;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // Pixel formats
  localparam logic [2:0] FMT_RGB565 = 3'd0;
  localparam logic [2:0] FMT_INDEX4 = 3'd1;
  localparam logic [2:0] FMT_INDEX6 = 3'd2;
  localparam logic [2:0] FMT_ALPHA8 = 3'd3;

  // Codecs
  localparam logic [2:0] CODEC_RAW   = 3'd0;
  localparam logic [2:0] CODEC_RLE   = 3'd1;
  localparam logic [2:0] CODEC_PAL16 = 3'd2;
  localparam logic [2:0] CODEC_PAL64 = 3'd3;

  // Register indexes (word address bits [3:2])
  localparam logic [1:0] REG_MAX_W     = 2'd0;
  localparam logic [1:0] REG_MAX_H     = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES = 2'd2;

  localparam logic [15:0] RST_MAX_W     = 16'd64;
  localparam logic [15:0] RST_MAX_H     = 16'd64;
  localparam logic [15:0] RST_MAX_BYTES = 16'd8192;

  localparam logic [16:0] BYTES_SAT  = 17'h1FFFF;
  localparam logic [7:0]  PAL16_MAX  = 8'd16;
  localparam logic [7:0]  PAL64_MAX  = 8'd64;
  localparam int          IDX_BITS   = 6;

  typedef struct packed {
    logic [15:0] max_w;
    logic [15:0] max_h;
    logic [15:0] max_bytes;
  } etv_cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [2:0]  fmt;
    logic [2:0]  codec;
    logic [31:0] pixels;
    logic        dim_fail;
  } etv_item_t;

endpackage

// ----- rtl/etv_cfg_regs.sv -----
module etv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [etv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [etv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [etv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output etv_pkg::etv_cfg_t                cfg
);
  import etv_pkg::*;

  logic [15:0] max_w_r, max_h_r, max_bytes_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_w_r     <= RST_MAX_W;
      max_h_r     <= RST_MAX_H;
      max_bytes_r <= RST_MAX_BYTES;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_W:     max_w_r     <= cfg_pwdata[15:0];
        REG_MAX_H:     max_h_r     <= cfg_pwdata[15:0];
        REG_MAX_BYTES: max_bytes_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_W:     cfg_prdata = {16'd0, max_w_r};
      REG_MAX_H:     cfg_prdata = {16'd0, max_h_r};
      REG_MAX_BYTES: cfg_prdata = {16'd0, max_bytes_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.max_w     = max_w_r;
  assign cfg.max_h     = max_h_r;
  assign cfg.max_bytes = max_bytes_r;

endmodule

// ----- rtl/etv_front.sv -----
module etv_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [etv_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  logic [etv_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  etv_pkg::etv_cfg_t                cfg,
  input  logic                             advance,
  output logic                             item_valid,
  output etv_pkg::etv_item_t               item
);
  import etv_pkg::*;

  logic        a_valid_r;
  etv_item_t   item_r;
  etv_item_t   item_nxt;
  logic [15:0] w, h;

  assign w = in_tdata[23:8];
  assign h = in_tdata[39:24];

  // Tile size product and dimension check are done here, ahead of the tile state.
  always_comb begin
    item_nxt.data     = in_tdata[7:0];
    item_nxt.first    = in_tuser[0];
    item_nxt.last     = in_tlast;
    item_nxt.fmt      = in_tuser[3:1];
    item_nxt.codec    = in_tuser[6:4];
    item_nxt.pixels   = {16'd0, w} * {16'd0, h};
    item_nxt.dim_fail = (w == 16'd0) || (h == 16'd0) || (w > cfg.max_w) || (h > cfg.max_h);
  end

  assign in_tready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = a_valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/etv_core.sv -----
module etv_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  etv_pkg::etv_item_t               item,
  input  etv_pkg::etv_cfg_t                cfg,
  input  logic                             out_tready,
  output logic                             advance,
  output logic                             out_tvalid,
  output logic [etv_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import etv_pkg::*;

  localparam logic [1:0] REC_LEN_RGB   = 2'd3;
  localparam logic [1:0] REC_LEN_ALPHA = 2'd2;

  // Tile state
  logic [2:0]  fmt_r, codec_r;
  logic [31:0] pexp_r, pseen_r;
  logic [16:0] bytes_r;
  logic [1:0]  phase_r;
  logic [7:0]  pal_r;
  logic [12:0] buf_r;
  logic [3:0]  bh_r;
  logic        failed_r;
  logic        out_valid_r, verdict_r;

  // Working state after a possible restart on the first word
  logic [2:0]  cur_fmt, cur_codec;
  logic [31:0] cur_pexp, cur_pseen;
  logic [16:0] cur_bytes;
  logic [1:0]  cur_phase;
  logic [7:0]  cur_pal;
  logic [12:0] cur_buf;
  logic [3:0]  cur_bh;
  logic        cur_failed;

  // Updated state
  logic [31:0] pseen_upd;
  logic [16:0] bytes_upd;
  logic [1:0]  phase_upd;
  logic [7:0]  pal_upd;
  logic [12:0] buf_upd;
  logic [3:0]  bh_upd;
  logic        failed_upd;

  logic        rle3, rle2, pal4, pal6, raw565, raw8;
  logic [31:0] rem;
  logic        rem_ge1, rem_ge2;
  logic [32:0] run_sum;
  logic        run_fail;
  logic [1:0]  phase_inc;
  logic        phase_wrap;
  logic        pos0, in_hdr;
  logic        hi_fail, lo_fail;
  logic [1:0]  nib_cnt;
  logic [12:0] merged, buf1, buf2;
  logic [3:0]  bh8, bh1, bh2;
  logic        c2;
  logic [5:0]  idx1, idx2;
  logic        six_fail;

  logic        ok_base, ok;
  logic [32:0] twice_p, half_p;
  logic [34:0] six_p, six_bytes;
  logic [33:0] pal4_len;
  logic [35:0] pal6_len;

  always_comb begin
    if (item.first) begin
      cur_fmt    = item.fmt;
      cur_codec  = item.codec;
      cur_pexp   = item.pixels;
      cur_pseen  = '0;
      cur_bytes  = '0;
      cur_phase  = '0;
      cur_pal    = '0;
      cur_buf    = '0;
      cur_bh     = '0;
      cur_failed = item.dim_fail;
    end else begin
      cur_fmt    = fmt_r;
      cur_codec  = codec_r;
      cur_pexp   = pexp_r;
      cur_pseen  = pseen_r;
      cur_bytes  = bytes_r;
      cur_phase  = phase_r;
      cur_pal    = pal_r;
      cur_buf    = buf_r;
      cur_bh     = bh_r;
      cur_failed = failed_r;
    end
  end

  assign rle3   = (cur_fmt == FMT_RGB565) && (cur_codec == CODEC_RLE);
  assign rle2   = (cur_fmt == FMT_ALPHA8) && (cur_codec == CODEC_RLE);
  assign pal4   = (cur_fmt == FMT_INDEX4) && (cur_codec == CODEC_PAL16);
  assign pal6   = (cur_fmt == FMT_INDEX6) && (cur_codec == CODEC_PAL64);
  assign raw565 = (cur_fmt == FMT_RGB565) && (cur_codec == CODEC_RAW);
  assign raw8   = (cur_fmt == FMT_ALPHA8) && (cur_codec == CODEC_RAW);

  // Pixels still owed; pixels_seen never passes the expected count.
  assign rem     = cur_pexp - cur_pseen;
  assign rem_ge1 = (rem != 32'd0);
  assign rem_ge2 = (rem[31:1] != 31'd0);

  // Run records
  assign run_sum    = {1'b0, cur_pseen} + {25'd0, item.data};
  assign run_fail   = (item.data == 8'd0) || (run_sum > {1'b0, cur_pexp});
  assign phase_inc  = cur_phase + 2'd1;
  assign phase_wrap = rle3 ? (phase_inc >= REC_LEN_RGB) : (phase_inc >= REC_LEN_ALPHA);

  // Palette header covers the count byte and two bytes per entry
  assign pos0   = (cur_bytes == 17'd0);
  assign in_hdr = cur_bytes < (17'd1 + {8'd0, cur_pal, 1'b0});

  // 4-bit indices, high nibble first
  assign hi_fail = rem_ge1 && ({4'd0, item.data[7:4]} >= cur_pal);
  assign lo_fail = rem_ge2 && ({4'd0, item.data[3:0]} >= cur_pal);
  assign nib_cnt = {1'b0, rem_ge1} + {1'b0, rem_ge2};

  // 6-bit indices, LSB first; at most two come out of one byte
  assign merged   = cur_buf | (13'(item.data) << cur_bh);
  assign bh8      = cur_bh + 4'd8;
  assign idx1     = merged[5:0];
  assign buf1     = merged >> IDX_BITS;
  assign bh1      = bh8 - 4'(IDX_BITS);
  assign c2       = (bh1 >= 4'(IDX_BITS)) && rem_ge2;
  assign idx2     = buf1[5:0];
  assign buf2     = buf1 >> IDX_BITS;
  assign bh2      = bh1 - 4'(IDX_BITS);
  assign six_fail = ({2'd0, idx1} >= cur_pal) || (c2 && ({2'd0, idx2} >= cur_pal));

  assign bytes_upd = (cur_bytes == BYTES_SAT) ? cur_bytes : cur_bytes + 17'd1;

  always_comb begin
    pseen_upd  = cur_pseen;
    phase_upd  = cur_phase;
    pal_upd    = cur_pal;
    buf_upd    = cur_buf;
    bh_upd     = cur_bh;
    failed_upd = cur_failed;
    if (rle3 || rle2) begin
      if (cur_phase == 2'd0) begin
        if (run_fail) begin
          failed_upd = 1'b1;
        end else begin
          pseen_upd = run_sum[31:0];
        end
      end
      phase_upd = phase_wrap ? 2'd0 : phase_inc;
    end else if (pal4 || pal6) begin
      if (pos0) begin
        pal_upd = item.data;
      end else if (!in_hdr) begin
        if (pal4) begin
          failed_upd = cur_failed | hi_fail | lo_fail;
          pseen_upd  = cur_pseen + {30'd0, nib_cnt};
        end else if (!rem_ge1) begin
          // all pixels seen: drop padding
          buf_upd = '0;
          bh_upd  = '0;
        end else begin
          failed_upd = cur_failed | six_fail;
          pseen_upd  = cur_pseen + (c2 ? 32'd2 : 32'd1);
          buf_upd    = c2 ? buf2 : buf1;
          bh_upd     = c2 ? bh2 : bh1;
        end
      end
    end
  end

  // Verdict on the updated state
  assign twice_p   = {cur_pexp, 1'b0};
  assign half_p    = ({1'b0, cur_pexp} + 33'd1) >> 1;
  assign six_p     = {1'b0, cur_pexp, 2'b00} + {2'b00, cur_pexp, 1'b0};
  assign six_bytes = (six_p + 35'd7) >> 3;
  assign pal4_len  = {1'b0, half_p} + {25'd0, pal_upd, 1'b1};
  assign pal6_len  = {1'b0, six_bytes} + {27'd0, pal_upd, 1'b1};

  assign ok_base = !failed_upd && (cur_pexp != 32'd0) && (bytes_upd <= {1'b0, cfg.max_bytes});

  always_comb begin
    if (raw565) begin
      ok = ok_base && ({16'd0, bytes_upd} == twice_p);
    end else if (raw8) begin
      ok = ok_base && ({15'd0, bytes_upd} == cur_pexp);
    end else if (rle3 || rle2) begin
      ok = ok_base && (pseen_upd == cur_pexp) && (phase_upd == 2'd0);
    end else if (pal4) begin
      ok = ok_base && (bytes_upd >= 17'd3) && (pal_upd != 8'd0) && (pal_upd <= PAL16_MAX) &&
           ({17'd0, bytes_upd} == pal4_len);
    end else if (pal6) begin
      ok = ok_base && (bytes_upd >= 17'd4) && (pal_upd != 8'd0) && (pal_upd <= PAL64_MAX) &&
           ({19'd0, bytes_upd} == pal6_len);
    end else begin
      ok = 1'b0;
    end
  end

  // A last word waits only while the verdict slot is full and not taken.
  assign advance = item_valid && (!item.last || !out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= '0;
      codec_r  <= '0;
      pexp_r   <= '0;
      pseen_r  <= '0;
      bytes_r  <= '0;
      phase_r  <= '0;
      pal_r    <= '0;
      buf_r    <= '0;
      bh_r     <= '0;
      failed_r <= 1'b0;
    end else if (advance) begin
      if (item.last) begin
        // clear tile state after the verdict
        fmt_r    <= '0;
        codec_r  <= '0;
        pexp_r   <= '0;
        pseen_r  <= '0;
        bytes_r  <= '0;
        phase_r  <= '0;
        pal_r    <= '0;
        buf_r    <= '0;
        bh_r     <= '0;
        failed_r <= 1'b0;
      end else begin
        fmt_r    <= cur_fmt;
        codec_r  <= cur_codec;
        pexp_r   <= cur_pexp;
        pseen_r  <= pseen_upd;
        bytes_r  <= bytes_upd;
        phase_r  <= phase_upd;
        pal_r    <= pal_upd;
        buf_r    <= buf_upd;
        bh_r     <= bh_upd;
        failed_r <= failed_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      verdict_r <= ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, verdict_r};

endmodule

// ----- rtl/encoded_tile_validator.sv -----
// Channel | Dir | Word
// in_     | in  | tdata: data_byte, tile_width, tile_height; tlast: last_byte;
//         |     | tuser: first_byte, color_format, codec
// out_    | out | tdata: tile_valid (bits 7:1 zero)
// cfg_    | in  | APB: 0x0 max_tile_width, 0x4 max_tile_height, 0x8 max_encoded_bytes
//
// One word per cycle while in_tready is high: the input register feeds the tile state and the verdict register.
// The verdict shows on out_ once its last word has passed the input register into the verdict register.
// in_tready drops only while a last word waits behind a verdict not yet taken.
// rst_n is synchronous: it drops the pipeline, clears tile state, restores register defaults.
module encoded_tile_validator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [23:8] tile_width, [39:24] tile_height
  input  logic [etv_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  // [0] first_byte, [3:1] color_format, [6:4] codec
  input  logic [etv_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] tile_valid, [7:1] zero
  output logic [etv_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [etv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [etv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [etv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import etv_pkg::*;

  etv_cfg_t  cfg;
  etv_item_t item;
  logic      item_valid;
  logic      advance;

  etv_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  etv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .cfg        (cfg),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  etv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .out_tready (out_tready),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/etv_checker.sv -----
`include "encoded_tile_validator_macros.svh"

module etv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [etv_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pready
);

  // A stalled verdict holds
  `ETV_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "verdict changed while stalled")

  // Only bit 0 carries the verdict
  `ETV_ASSERT_IMP(a_out_pad, clk, rst_n, out_tvalid, out_tdata[7:1] == 7'd0, "verdict padding not zero")

  // Input backpressure comes only from an untaken verdict
  `ETV_ASSERT_IMP(a_in_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without a waiting verdict")

  // Register port never inserts wait states
  `ETV_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_psel && cfg_penable, cfg_pready, "register access stalled")

endmodule

bind encoded_tile_validator etv_checker u_etv_checker (.*);
